/* hdl/lav_pkg.sv */
// ----------------------------------------------------------------------------
// lav_pkg
// Shared widths, types and fixed-point helpers for the look-at view matrix.
// ----------------------------------------------------------------------------
package lav_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int IN_W       = 32;
   localparam int AXO_W      = 18;
   localparam int OFS_W      = 32;
   localparam int AXIS_W     = FRAC_BITS + 2;
   localparam int PR_W       = IN_W + AXIS_W;
   localparam int CROSS_W    = PR_W + 1;
   localparam int MAG_W      = CROSS_W;
   localparam int NORM_TOP   = 29;
   localparam int NRM_W      = NORM_TOP + 1;
   localparam int SQ_W       = 2 * NRM_W;
   localparam int SUM_W      = SQ_W + 2;
   localparam int ROOT_STEPS = (SUM_W + 1) / 2;
   localparam int RT_W       = SUM_W + 1;
   localparam int RTO_W      = NRM_W + 1;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int NUM_W      = NRM_W + FRAC_BITS + 1;
   localparam int NCH        = (MAG_W + 7) / 8;
   localparam int POS_W      = $clog2(NCH * 8);

   localparam int XA [6] = '{1, 2, 2, 0, 0, 1};
   localparam int XB [6] = '{2, 1, 0, 2, 1, 0};

   typedef logic signed [AXIS_W-1:0] axis_type;
   typedef axis_type [2:0] axis3_type;
   typedef logic [2:0][IN_W-1:0] word3_type;

   typedef struct packed {
      word3_type cam;
      word3_type up;
      axis3_type fwd;
   } side_type;

   typedef struct packed {
      logic [2:0]            sgn;
      logic [2:0][MAG_W-1:0] mag;
   } smag_type;

   typedef struct packed {
      logic [2:0]            sgn;
      logic [2:0][NRM_W-1:0] nm;
      logic                  zero;
      side_type              side;
   } nctx_type;

   typedef struct packed {
      logic [2:0][AXO_W-1:0] rgt;
      logic [2:0][AXO_W-1:0] upa;
      logic [2:0][AXO_W-1:0] fwd;
      logic [2:0][OFS_W-1:0] ofs;
   } rsp_type;

   function automatic logic signed [63:0] rshift_round(input logic signed [63:0] v);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return v[63] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic [OFS_W-1:0] sat_ofs(input logic signed [63:0] d);
      logic signed [63:0] r;
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (OFS_W - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (OFS_W - 1));
      r = -rshift_round(d);
      if (r > hi) r = hi;
      if (r < lo) r = lo;
      return r[OFS_W-1:0];
   endfunction

   function automatic axis_type clamp_axis(input logic signed [63:0] t);
      logic signed [63:0] lim;
      logic signed [63:0] r;
      lim = 64'sd1 <<< FRAC_BITS;
      r = t;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r[AXIS_W-1:0];
   endfunction

   function automatic logic [AXO_W-1:0] to_axo(input axis_type a);
      logic [AXO_W-1:0] r;
      for (int i = 0; i < AXO_W; i++) begin
         r[i] = a[(i < AXIS_W) ? i : AXIS_W - 1];
      end
      return r;
   endfunction

endpackage

/* hdl/lav_norm.sv */
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalizer: range scaling, squares, digit-by-digit square
// root and three restoring dividers, one step per stage.
// ----------------------------------------------------------------------------
module lav_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  lav_pkg::smag_type  in_vec,
   input  lav_pkg::side_type  in_side,
   output logic               out_valid,
   output lav_pkg::axis3_type out_axis,
   output lav_pkg::side_type  out_side
);
   import lav_pkg::*;

   localparam int NSTG = 8 + ROOT_STEPS + Q_W;

   logic [NSTG-1:0] vld_ff;

   logic [2:0]            sgn0_ff, sgn1_ff, sgn2_ff;
   logic [2:0][MAG_W-1:0] mag0_ff, mag1_ff, mag2_ff;
   side_type              side0_ff, side1_ff, side2_ff;

   logic [NCH*8-1:0]      any_in;
   logic [NCH-1:0]        nz_in, nz1_ff;
   logic [NCH-1:0][2:0]   idx_in, idx1_ff;

   logic [POS_W-1:0]      pos_in, pos2_ff;
   logic                  zero_in, zero2_ff;

   logic [MAG_W-1:0]      wide;
   nctx_type              ctx_in, ctx3_ff, ctx4_ff;
   logic [SQ_W-1:0]       sq4_ff [3];

   logic [RT_W-1:0]       rn_ff [ROOT_STEPS+1];
   logic [RT_W-1:0]       rr_ff [ROOT_STEPS+1];
   nctx_type              rctx_ff [ROOT_STEPS+1];

   logic [2:0][NUM_W-1:0] dr_ff [Q_W+1];
   logic [2:0][Q_W-1:0]   dq_ff [Q_W+1];
   logic [RTO_W-1:0]      dm_ff [Q_W+1];
   nctx_type              dctx_ff [Q_W+1];

   logic [RTO_W-1:0]      root;
   axis3_type             axis_in, axis_ff;
   side_type              oside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_comb begin
      any_in = (NCH*8)'(mag0_ff[0] | mag0_ff[1] | mag0_ff[2]);
      for (int c = 0; c < NCH; c++) begin
         nz_in[c]  = 1'b0;
         idx_in[c] = '0;
         for (int b = 0; b < 8; b++) begin
            if (any_in[c*8+b]) begin
               nz_in[c]  = 1'b1;
               idx_in[c] = 3'(b);
            end
         end
      end
   end

   always_comb begin
      pos_in  = '0;
      zero_in = ~|nz1_ff;
      for (int c = 0; c < NCH; c++) begin
         if (nz1_ff[c]) begin
            pos_in = POS_W'(c * 8 + int'(idx1_ff[c]));
         end
      end
   end

   always_comb begin
      ctx_in.sgn  = sgn2_ff;
      ctx_in.zero = zero2_ff;
      ctx_in.side = side2_ff;
      for (int i = 0; i < 3; i++) begin
         if (pos2_ff >= POS_W'(NORM_TOP)) begin
            wide = mag2_ff[i] >> (pos2_ff - POS_W'(NORM_TOP));
         end else begin
            wide = mag2_ff[i] << (POS_W'(NORM_TOP) - pos2_ff);
         end
         ctx_in.nm[i] = wide[NRM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sgn0_ff  <= in_vec.sgn;
         mag0_ff  <= in_vec.mag;
         side0_ff <= in_side;
         sgn1_ff  <= sgn0_ff;
         mag1_ff  <= mag0_ff;
         side1_ff <= side0_ff;
         nz1_ff   <= nz_in;
         idx1_ff  <= idx_in;
         sgn2_ff  <= sgn1_ff;
         mag2_ff  <= mag1_ff;
         side2_ff <= side1_ff;
         pos2_ff  <= pos_in;
         zero2_ff <= zero_in;
         ctx3_ff  <= ctx_in;
         ctx4_ff  <= ctx3_ff;
         for (int i = 0; i < 3; i++) begin
            sq4_ff[i] <= SQ_W'(ctx3_ff.nm[i]) * SQ_W'(ctx3_ff.nm[i]);
         end
         rn_ff[0]   <= RT_W'(sq4_ff[0]) + RT_W'(sq4_ff[1]) + RT_W'(sq4_ff[2]);
         rr_ff[0]   <= '0;
         rctx_ff[0] <= ctx4_ff;
      end
   end

   for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
      localparam logic [RT_W-1:0] BITV = RT_W'(1) << (2 * (ROOT_STEPS - 1 - k));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rn_ff[k] >= rr_ff[k] + BITV) begin
               rn_ff[k+1] <= rn_ff[k] - (rr_ff[k] + BITV);
               rr_ff[k+1] <= (rr_ff[k] >> 1) + BITV;
            end else begin
               rn_ff[k+1] <= rn_ff[k];
               rr_ff[k+1] <= rr_ff[k] >> 1;
            end
            rctx_ff[k+1] <= rctx_ff[k];
         end
      end
   end

   assign root = rr_ff[ROOT_STEPS][RTO_W-1:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            dr_ff[0][i] <= NUM_W'({rctx_ff[ROOT_STEPS].nm[i], FRAC_BITS'(0)})
                         + NUM_W'(root >> 1);
         end
         dq_ff[0]   <= '0;
         dm_ff[0]   <= root;
         dctx_ff[0] <= rctx_ff[ROOT_STEPS];
      end
   end

   for (genvar j = 0; j < Q_W; j++) begin : g_div
      localparam int KB = Q_W - 1 - j;
      logic [NUM_W-1:0] dvs;
      assign dvs = NUM_W'(dm_ff[j]) << KB;
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               if (dr_ff[j][i] >= dvs) begin
                  dr_ff[j+1][i] <= dr_ff[j][i] - dvs;
                  dq_ff[j+1][i] <= dq_ff[j][i] | (Q_W'(1) << KB);
               end else begin
                  dr_ff[j+1][i] <= dr_ff[j][i];
                  dq_ff[j+1][i] <= dq_ff[j][i];
               end
            end
            dm_ff[j+1]   <= dm_ff[j];
            dctx_ff[j+1] <= dctx_ff[j];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dctx_ff[Q_W].zero) begin
            axis_in[i] = '0;
         end else if (dctx_ff[Q_W].sgn[i]) begin
            axis_in[i] = -AXIS_W'({1'b0, dq_ff[Q_W][i]});
         end else begin
            axis_in[i] = AXIS_W'({1'b0, dq_ff[Q_W][i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         axis_ff  <= axis_in;
         oside_ff <= dctx_ff[Q_W].side;
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_axis  = axis_ff;
   assign out_side  = oside_ff;

endmodule

/* hdl/lav_rows.sv */
// ----------------------------------------------------------------------------
// lav_rows
// Back end: true up axis as forward cross right, and the three row offsets.
// ----------------------------------------------------------------------------
module lav_rows (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  lav_pkg::axis3_type in_rgt,
   input  lav_pkg::side_type  in_side,
   output logic               out_valid,
   output lav_pkg::rsp_type   out_rsp
);
   import lav_pkg::*;

   localparam int PA_W = 2 * AXIS_W;

   logic [3:0] vld_ff;

   logic signed [PA_W-1:0] pa0_ff [6];
   logic signed [PR_W-1:0] pr0_ff [3];
   logic signed [PR_W-1:0] pf0_ff [3];
   logic signed [PR_W-1:0] pu2_ff [3];
   axis3_type              rgt0_ff, fwd0_ff, rgt1_ff, fwd1_ff, rgt2_ff, fwd2_ff;
   axis3_type              tup_in, tup1_ff, tup2_ff;
   word3_type              cam0_ff, cam1_ff;
   logic [OFS_W-1:0]       or1_ff, of1_ff, or2_ff, of2_ff;
   rsp_type                rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         tup_in[k] = clamp_axis(rshift_round(64'(pa0_ff[2*k]) - 64'(pa0_ff[2*k+1])));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int p = 0; p < 6; p++) begin
            pa0_ff[p] <= PA_W'($signed(in_side.fwd[XA[p]])) * PA_W'($signed(in_rgt[XB[p]]));
         end
         for (int i = 0; i < 3; i++) begin
            pr0_ff[i] <= PR_W'($signed(in_side.cam[i])) * PR_W'($signed(in_rgt[i]));
            pf0_ff[i] <= PR_W'($signed(in_side.cam[i])) * PR_W'($signed(in_side.fwd[i]));
         end
         rgt0_ff <= in_rgt;
         fwd0_ff <= in_side.fwd;
         cam0_ff <= in_side.cam;

         tup1_ff <= tup_in;
         or1_ff  <= sat_ofs(64'(pr0_ff[0]) + 64'(pr0_ff[1]) + 64'(pr0_ff[2]));
         of1_ff  <= sat_ofs(64'(pf0_ff[0]) + 64'(pf0_ff[1]) + 64'(pf0_ff[2]));
         rgt1_ff <= rgt0_ff;
         fwd1_ff <= fwd0_ff;
         cam1_ff <= cam0_ff;

         for (int i = 0; i < 3; i++) begin
            pu2_ff[i] <= PR_W'($signed(cam1_ff[i])) * PR_W'($signed(tup1_ff[i]));
         end
         tup2_ff <= tup1_ff;
         or2_ff  <= or1_ff;
         of2_ff  <= of1_ff;
         rgt2_ff <= rgt1_ff;
         fwd2_ff <= fwd1_ff;

         for (int i = 0; i < 3; i++) begin
            rsp_ff.rgt[i] <= to_axo(rgt2_ff[i]);
            rsp_ff.upa[i] <= to_axo(tup2_ff[i]);
            rsp_ff.fwd[i] <= to_axo(fwd2_ff[i]);
         end
         rsp_ff.ofs[0] <= or2_ff;
         rsp_ff.ofs[1] <= sat_ofs(64'(pu2_ff[0]) + 64'(pu2_ff[1]) + 64'(pu2_ff[2]));
         rsp_ff.ofs[2] <= of2_ff;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_rsp   = rsp_ff;

endmodule

/* hdl/look_at_view_matrix.sv */
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Fixed-point 3x4 look-at view matrix from camera, up hint and target.
// ----------------------------------------------------------------------------
// The block accepts one item per clock unless stalled and builds its matrix
// through one input register, two normalizers of 56 stages each (31 square
// root steps and 17 divider steps dominate), one cross product stage and a
// four-stage back end for the true up axis and the offsets. A stall on the
// result side freezes the whole pipeline, so req_stall is high exactly while
// a finished item waits to be taken.
module look_at_view_matrix (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [lav_pkg::IN_W-1:0] req_cam_x,
   input  logic [lav_pkg::IN_W-1:0] req_cam_y,
   input  logic [lav_pkg::IN_W-1:0] req_cam_z,
   input  logic [lav_pkg::IN_W-1:0] req_up_x,
   input  logic [lav_pkg::IN_W-1:0] req_up_y,
   input  logic [lav_pkg::IN_W-1:0] req_up_z,
   input  logic [lav_pkg::IN_W-1:0] req_tgt_x,
   input  logic [lav_pkg::IN_W-1:0] req_tgt_y,
   input  logic [lav_pkg::IN_W-1:0] req_tgt_z,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [lav_pkg::AXO_W-1:0] rsp_right_x,
   output logic [lav_pkg::AXO_W-1:0] rsp_right_y,
   output logic [lav_pkg::AXO_W-1:0] rsp_right_z,
   output logic [lav_pkg::OFS_W-1:0] rsp_right_offset,
   output logic [lav_pkg::AXO_W-1:0] rsp_upaxis_x,
   output logic [lav_pkg::AXO_W-1:0] rsp_upaxis_y,
   output logic [lav_pkg::AXO_W-1:0] rsp_upaxis_z,
   output logic [lav_pkg::OFS_W-1:0] rsp_upaxis_offset,
   output logic [lav_pkg::AXO_W-1:0] rsp_fwd_x,
   output logic [lav_pkg::AXO_W-1:0] rsp_fwd_y,
   output logic [lav_pkg::AXO_W-1:0] rsp_fwd_z,
   output logic [lav_pkg::OFS_W-1:0] rsp_fwd_offset
);
   import lav_pkg::*;

   logic adv;
   logic vld0_ff, vldc_ff;
   word3_type cam0_ff, up0_ff, tgt0_ff;

   logic signed [IN_W:0] diff;
   logic [IN_W:0]        dmag;
   smag_type             n1_vec, n2_vec;
   side_type             n1_side, n1_oside, n2_oside, c_side_ff;
   logic                 n1_valid, n2_valid;
   axis3_type            fwd_axis, rgt_axis;

   logic signed [PR_W-1:0]    pc_ff [6];
   logic signed [CROSS_W-1:0] cr;

   rsp_type rsp;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vldc_ff <= 1'b0;
      end else if (adv) begin
         vld0_ff <= req_valid;
         vldc_ff <= n1_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cam0_ff <= {req_cam_z, req_cam_y, req_cam_x};
         up0_ff  <= {req_up_z, req_up_y, req_up_x};
         tgt0_ff <= {req_tgt_z, req_tgt_y, req_tgt_x};
         for (int p = 0; p < 6; p++) begin
            pc_ff[p] <= PR_W'($signed(n1_oside.up[XA[p]])) * PR_W'($signed(fwd_axis[XB[p]]));
         end
         c_side_ff.cam <= n1_oside.cam;
         c_side_ff.up  <= n1_oside.up;
         c_side_ff.fwd <= fwd_axis;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         diff = (IN_W+1)'($signed(cam0_ff[i])) - (IN_W+1)'($signed(tgt0_ff[i]));
         dmag = diff[IN_W] ? (IN_W+1)'(-diff) : (IN_W+1)'(diff);
         n1_vec.sgn[i] = diff[IN_W];
         n1_vec.mag[i] = MAG_W'(dmag);
      end
      n1_side.cam = cam0_ff;
      n1_side.up  = up0_ff;
      n1_side.fwd = '0;
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cr = CROSS_W'(pc_ff[2*k]) - CROSS_W'(pc_ff[2*k+1]);
         n2_vec.sgn[k] = cr[CROSS_W-1];
         n2_vec.mag[k] = cr[CROSS_W-1] ? MAG_W'(-cr) : MAG_W'(cr);
      end
   end

   lav_norm u_norm_fwd (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld0_ff),
      .in_vec    (n1_vec),
      .in_side   (n1_side),
      .out_valid (n1_valid),
      .out_axis  (fwd_axis),
      .out_side  (n1_oside)
   );

   lav_norm u_norm_rgt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vldc_ff),
      .in_vec    (n2_vec),
      .in_side   (c_side_ff),
      .out_valid (n2_valid),
      .out_axis  (rgt_axis),
      .out_side  (n2_oside)
   );

   lav_rows u_rows (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (n2_valid),
      .in_rgt    (rgt_axis),
      .in_side   (n2_oside),
      .out_valid (rsp_valid),
      .out_rsp   (rsp)
   );

   assign rsp_right_x       = rsp.rgt[0];
   assign rsp_right_y       = rsp.rgt[1];
   assign rsp_right_z       = rsp.rgt[2];
   assign rsp_right_offset  = rsp.ofs[0];
   assign rsp_upaxis_x      = rsp.upa[0];
   assign rsp_upaxis_y      = rsp.upa[1];
   assign rsp_upaxis_z      = rsp.upa[2];
   assign rsp_upaxis_offset = rsp.ofs[1];
   assign rsp_fwd_x         = rsp.fwd[0];
   assign rsp_fwd_y         = rsp.fwd[1];
   assign rsp_fwd_z         = rsp.fwd[2];
   assign rsp_fwd_offset    = rsp.ofs[2];

   // A zero forward axis forces zero right and true up axes.
   a_fwd_zero_axes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fwd_x == '0 && rsp_fwd_y == '0 && rsp_fwd_z == '0
      |-> rsp_right_x == '0 && rsp_right_y == '0 && rsp_right_z == '0 &&
          rsp_upaxis_x == '0 && rsp_upaxis_y == '0 && rsp_upaxis_z == '0)
      else $error("zero forward axis gave a nonzero right or up axis");

   // A zero right axis leaves no translation on the first two rows.
   a_rgt_zero_ofs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_right_x == '0 && rsp_right_y == '0 && rsp_right_z == '0
      |-> rsp_right_offset == '0 && rsp_upaxis_offset == '0)
      else $error("zero right axis gave a nonzero offset");

   // A zero forward axis leaves no translation on the forward row.
   a_fwd_zero_ofs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fwd_x == '0 && rsp_fwd_y == '0 && rsp_fwd_z == '0
      |-> rsp_fwd_offset == '0)
      else $error("zero forward axis gave a nonzero offset");

endmodule
